@@ rtl/mi3_pkg.sv @@
// Package for the 3x3 matrix inverse: widths, status codes, cofactor index table.
// No dependencies; used by every other file of the block.
package mi3_pkg;

    localparam int ELEM_W  = 32;              // element width, Q8.24
    localparam int FRAC_W  = 24;              // fraction bits
    localparam int THR_W   = ELEM_W - 1;      // threshold register width
    localparam int PROD_W  = 2 * ELEM_W;      // element product
    localparam int COF_W   = PROD_W + 1;      // cofactor, signed
    localparam int LO_W    = ELEM_W;          // low slice of a cofactor
    localparam int HI_W    = COF_W - LO_W;    // high slice of a cofactor, signed
    localparam int TERM_W  = ELEM_W + COF_W + 1;
    localparam int DET_W   = TERM_W + 2;      // sum of three terms
    localparam int ADET_W  = TERM_W;          // |det| fits here
    localparam int DV_W    = ADET_W + 1;      // divisor 2|det|
    localparam int NUM_W   = COF_W + 2 * FRAC_W + 1;  // 2|C|*2^2F + |det|
    localparam int QW      = ELEM_W + 2;      // quotient bits, top one = overflow
    localparam int DIV_W   = (DV_W + QW - 1 > NUM_W) ? DV_W + QW - 1 : NUM_W;
    localparam int NSTEP   = QW;              // divider stages
    localparam int PRE_ST  = 7;               // stages ahead of the divider
    localparam int NST     = PRE_ST + NSTEP + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic [DIV_W-1:0]         t_rem;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_NEAR     = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    // cofactor k = m[a]*m[b] - m[c]*m[d], elements numbered row by row from 0
    localparam int unsigned COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

@@ rtl/mi3_if.sv @@
// Valid/ready channel interfaces for the matrix inverse: matrix in, inverse out.
// Depends on mi3_pkg.
interface mi3_in_if;
    logic                  valid;
    logic                  ready;
    mi3_pkg::t_elem        m11, m12, m13, m21, m22, m23, m31, m32, m33;
    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface mi3_out_if;
    logic                  valid;
    logic                  ready;
    mi3_pkg::t_elem        r11, r12, r13, r21, r22, r23, r31, r32, r33;
    logic [1:0]            status;
    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    status, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    status, output ready);
endinterface

@@ rtl/matrix_inverse_3x3.sv @@
// 3x3 matrix inverse by adjugate, Q8.24 in and out. Stages from
// transfer in to result valid: 7 stages of products, cofactors, determinant and divider set-up,
// 34 divider stages (one quotient bit each), one output stage.
// Throughput one matrix per cycle unless the output stalls; stalls collapse bubbles, stage by stage.
// Synchronous active-low reset clears all valid bits and sets the threshold to 2.
module matrix_inverse_3x3 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mi3_pkg::THR_W-1:0]   i_cfg_wdata,
    mi3_in_if.sink                      i_in,
    mi3_out_if.source                   o_out
);
    import mi3_pkg::*;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // ---------------- flow control ----------------
    // Stage i loads when it is empty or its item moves on.
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_rdy;

    always_comb begin
        w_rdy[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign i_in.ready = w_rdy[0];

    t_elem w_m [9];
    assign w_m[0] = i_in.m11;
    assign w_m[1] = i_in.m12;
    assign w_m[2] = i_in.m13;
    assign w_m[3] = i_in.m21;
    assign w_m[4] = i_in.m22;
    assign w_m[5] = i_in.m23;
    assign w_m[6] = i_in.m31;
    assign w_m[7] = i_in.m32;
    assign w_m[8] = i_in.m33;

    // ---------------- stage 0: 18 element products ----------------
    logic signed [PROD_W-1:0] r_p [18];
    t_elem                    r_m0 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int k = 0; k < 9; k++) begin
                r_p[2*k]   <= PROD_W'(w_m[COF_IDX[k][0]]) * PROD_W'(w_m[COF_IDX[k][1]]);
                r_p[2*k+1] <= PROD_W'(w_m[COF_IDX[k][2]]) * PROD_W'(w_m[COF_IDX[k][3]]);
            end
            r_m0 <= w_m;
        end
    end

    // ---------------- stage 1: cofactors ----------------
    t_cof  r_c1 [9];
    t_elem r_m1 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int k = 0; k < 9; k++) begin
                r_c1[k] <= COF_W'(r_p[2*k]) - COF_W'(r_p[2*k+1]);
            end
            r_m1 <= r_m0;
        end
    end

    // ---------------- stage 2: determinant partial products ----------------
    // det = m11*C11 + m12*C21 + m13*C31; each cofactor split into a low
    // unsigned slice and a high signed slice to keep multipliers near 32x32.
    logic signed [COF_W-1:0] r_pl [3];
    logic signed [COF_W-1:0] r_ph [3];
    t_cof                    r_c2 [9];
    t_elem                   r_m2 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= COF_W'(r_m1[j]) *
                           COF_W'($signed({1'b0, r_c1[3*j][LO_W-1:0]}));
                r_ph[j] <= COF_W'(r_m1[j]) *
                           COF_W'($signed(r_c1[3*j][COF_W-1:LO_W]));
            end
            r_c2 <= r_c1;
            r_m2 <= r_m1;
        end
    end

    // ---------------- stage 3: recombine slices ----------------
    logic signed [TERM_W-1:0] r_t [3];
    t_cof                     r_c3 [9];
    t_elem                    r_m3 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (TERM_W'(r_ph[j]) <<< LO_W) + TERM_W'(r_pl[j]);
            end
            r_c3 <= r_c2;
            r_m3 <= r_m2;
        end
    end

    // ---------------- stage 4: determinant ----------------
    logic signed [DET_W-1:0] r_det;
    t_cof                    r_c4 [9];
    t_elem                   r_m4 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_det <= DET_W'(r_t[0]) + DET_W'(r_t[1]) + DET_W'(r_t[2]);
            r_c4  <= r_c3;
            r_m4  <= r_m3;
        end
    end

    // ---------------- stage 5: magnitudes and signs ----------------
    logic [DET_W-1:0]  w_adet;
    assign w_adet = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

    logic [ADET_W-1:0] r_ad5;
    logic              r_dz5;
    logic [COF_W-1:0]  r_ac5 [9];
    logic [8:0]        r_ng5;
    t_elem             r_m5 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_ad5 <= w_adet[ADET_W-1:0];
            r_dz5 <= (r_det == '0);
            for (int k = 0; k < 9; k++) begin
                r_ac5[k] <= r_c4[k][COF_W-1] ? COF_W'(-r_c4[k]) : COF_W'(r_c4[k]);
                r_ng5[k] <= r_c4[k][COF_W-1] ^ r_det[DET_W-1];
            end
            r_m5 <= r_m4;
        end
    end

    // ---------------- stage 6: dividend, divisor, near-singular test ----------------
    // Rounded quotient = floor((2|C|*2^2F + |D|) / (2|D|)), ties away from zero.
    t_rem            r_num [9];
    logic [DV_W-1:0] r_dv;
    logic            r_near6;
    logic            r_dz6;
    logic [8:0]      r_ng6;
    t_elem           r_m6 [9];
    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            for (int k = 0; k < 9; k++) begin
                r_num[k] <= (t_rem'(r_ac5[k]) << (2 * FRAC_W + 1)) + t_rem'(r_ad5);
            end
            r_dv    <= {r_ad5, 1'b0};
            r_near6 <= (r_ad5 < (ADET_W'(r_thr) << (2 * FRAC_W)));
            r_dz6   <= r_dz5;
            r_ng6   <= r_ng5;
            r_m6    <= r_m5;
        end
    end

    // ---------------- stages 7..40: nine pipelined dividers ----------------
    logic [QW-1:0] w_q [9];
    logic [8:0]    w_qneg;

    for (genvar k = 0; k < 9; k++) begin : g_div
        mi3_div_pipe u_div (
            .i_clk (i_clk),
            .i_en  (w_rdy[PRE_ST +: NSTEP]),
            .i_num (r_num[k]),
            .i_dv  (r_dv),
            .i_neg (r_ng6[k]),
            .o_q   (w_q[k]),
            .o_neg (w_qneg[k])
        );
    end

    // side flags and pass-through elements ride alongside the divider
    logic  r_dzd   [NSTEP];
    logic  r_neard [NSTEP];
    t_elem r_md    [NSTEP][9];
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTEP; s++) begin
            if (w_rdy[PRE_ST + s]) begin
                if (s == 0) begin
                    r_dzd[s]   <= r_dz6;
                    r_neard[s] <= r_near6;
                    r_md[s]    <= r_m6;
                end else begin
                    r_dzd[s]   <= r_dzd[s-1];
                    r_neard[s] <= r_neard[s-1];
                    r_md[s]    <= r_md[s-1];
                end
            end
        end
    end

    // ---------------- stage 41: saturate, sign, status ----------------
    t_elem      w_res [9];
    logic [8:0] w_sat;
    always_comb begin
        logic [QW-1:0] lim;
        logic [QW-1:0] qv;
        for (int k = 0; k < 9; k++) begin
            lim = w_qneg[k] ? (QW'(1) << (ELEM_W - 1)) : ((QW'(1) << (ELEM_W - 1)) - QW'(1));
            w_sat[k] = (w_q[k] > lim);
            qv       = w_sat[k] ? lim : w_q[k];
            w_res[k] = w_qneg[k] ? -t_elem'(qv[ELEM_W-1:0]) : t_elem'(qv[ELEM_W-1:0]);
        end
    end

    t_elem   r_r [9];
    t_status r_status;
    always_ff @(posedge i_clk) begin
        if (w_rdy[NST-1]) begin
            if (r_dzd[NSTEP-1]) begin
                r_r      <= r_md[NSTEP-1];
                r_status <= ST_SINGULAR;
            end else begin
                r_r <= w_res;
                if (|w_sat) begin
                    r_status <= ST_SAT;
                end else if (r_neard[NSTEP-1]) begin
                    r_status <= ST_NEAR;
                end else begin
                    r_status <= ST_OK;
                end
            end
        end
    end

    assign o_out.valid  = r_v[NST-1];
    assign o_out.r11    = r_r[0];
    assign o_out.r12    = r_r[1];
    assign o_out.r13    = r_r[2];
    assign o_out.r21    = r_r[3];
    assign o_out.r22    = r_r[4];
    assign o_out.r23    = r_r[5];
    assign o_out.r31    = r_r[6];
    assign o_out.r32    = r_r[7];
    assign o_out.r33    = r_r[8];
    assign o_out.status = r_status;

endmodule

@@ rtl/mi3_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, for one element.
// Depends on mi3_pkg. Stage enables come from the top level's flow control.
module mi3_div_pipe (
    input  logic                         i_clk,
    input  logic [mi3_pkg::NSTEP-1:0]    i_en,
    input  mi3_pkg::t_rem                i_num,
    input  logic [mi3_pkg::DV_W-1:0]     i_dv,
    input  logic                         i_neg,
    output logic [mi3_pkg::QW-1:0]       o_q,
    output logic                         o_neg
);
    import mi3_pkg::*;

    t_rem              r_rem [NSTEP];
    logic [DV_W-1:0]   r_dv  [NSTEP];
    logic [QW-1:0]     r_q   [NSTEP];
    logic              r_neg [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int K = QW - 1 - s;
        t_rem            w_rem;
        logic [DV_W-1:0] w_dv;
        logic [QW-1:0]   w_q;
        logic            w_neg;
        logic [DIV_W:0]  w_diff;

        if (s == 0) begin : g_first
            assign w_rem = i_num;
            assign w_dv  = i_dv;
            assign w_q   = '0;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_dv  = r_dv[s-1];
            assign w_q   = r_q[s-1];
            assign w_neg = r_neg[s-1];
        end

        assign w_diff = {1'b0, w_rem} - {1'b0, (t_rem'(w_dv) << K)};

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_dv[s]  <= w_dv;
                r_neg[s] <= w_neg;
                if (!w_diff[DIV_W]) begin
                    r_rem[s] <= w_diff[DIV_W-1:0];
                    r_q[s]   <= w_q | (QW'(1) << K);
                end else begin
                    r_rem[s] <= w_rem;
                    r_q[s]   <= w_q;
                end
            end
        end
    end

    assign o_q   = r_q[NSTEP-1];
    assign o_neg = r_neg[NSTEP-1];

endmodule

@@ rtl/mi3_checker.sv @@
// Port-level checks for matrix_inverse_3x3, attached by bind.
// Depends on mi3_pkg and the top level's ports.
module mi3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_r11
);
    import mi3_pkg::*;

    // a result held back stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_r11))
        else $error("result changed while stalled");

    // input is refused only when the pipe is full behind a stalled result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused without output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_r11       (o_out.r11)
);
